[hdl/pmdf_pkg.sv]
// shared types, constants and register codes for the porous media drag unit
package pmdf_pkg;

	localparam int VEL_FRAC_BITS = 16;
	localparam logic [31:0] SMALL = 32'd1;

	// front pipeline layout
	localparam int R_BITS = 48;
	localparam int S_BITS = 64;
	localparam int RT_STEPS = 32;
	localparam int F_SQ = 1;
	localparam int F_SUM = 2;
	localparam int F_RT0 = 3;
	localparam int F_R0 = 1;
	localparam int F_SCHK = F_R0 + R_BITS;
	localparam int F_S0 = F_SCHK + 1;
	localparam int F_LAST = F_S0 + S_BITS - 1;

	localparam int ADDR_W = 5;

	localparam logic [30:0] RST_VISCOUS = 31'd11796480;
	localparam logic [30:0] RST_INERTIAL = 31'd65536;
	localparam logic [31:0] RST_NU = 32'd4295;
	localparam logic [30:0] RST_SCALE = 31'd65536;

	typedef enum logic [2:0] {
		REG_VISCOUS,
		REG_INERTIAL,
		REG_NU,
		REG_SCALE_X,
		REG_SCALE_Y,
		REG_SCALE_Z
	} reg_idx_t;

	typedef struct packed {
		logic [15:0] porosity;
		logic [31:0] pore_diameter;
		logic signed [31:0] velocity_x;
		logic signed [31:0] velocity_y;
		logic signed [31:0] velocity_z;
	} pmdf_in_t;

	typedef struct packed {
		logic signed [31:0] force_x;
		logic signed [31:0] force_y;
		logic signed [31:0] force_z;
		logic saturated;
	} pmdf_out_t;

	// front to back: ratio S, speed and velocity magnitudes
	typedef struct packed {
		logic [63:0] s;
		logic s_inf;
		logic [31:0] mag;
		logic [2:0][31:0] um;
		logic [2:0] neg;
	} pmdf_ratio_t;

	typedef struct packed {
		logic [62:0] cn;
		logic [30:0] c2;
		logic [2:0][30:0] scale;
	} pmdf_coef_t;

endpackage

[hdl/pmdf_mul64.sv]
// 64 by 64 unsigned multiplier, four registered 32 by 32 partial products
module pmdf_mul64 (
	input logic clk,
	input logic en,
	input logic [63:0] a,
	input logic [63:0] b,
	output logic [127:0] p
);
	logic [63:0] ll_s1, lh_s1, hl_s1, hh_s1;
	logic [64:0] mid;

	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1 <= 64'(a[31:0]) * 64'(b[31:0]);
			lh_s1 <= 64'(a[31:0]) * 64'(b[63:32]);
			hl_s1 <= 64'(a[63:32]) * 64'(b[31:0]);
			hh_s1 <= 64'(a[63:32]) * 64'(b[63:32]);
		end
	end

	assign mid = {1'b0, lh_s1} + {1'b0, hl_s1};
	assign p = {hh_s1, ll_s1} + {31'd0, mid, 32'd0};
endmodule

[hdl/pmdf_front.sv]
// front pipeline: porosity ratio and diameter division, speed square root
module pmdf_front (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_vld,
	input pmdf_pkg::pmdf_in_t in_data,
	output logic out_vld,
	output pmdf_pkg::pmdf_ratio_t out_data
);
	import pmdf_pkg::*;

	typedef struct packed {
		logic [15:0] a;
		logic [16:0] om;
		logic [31:0] d;
		logic [16:0] r_rem;
		logic [47:0] r_q;
		logic s_inf;
		logic [31:0] s_rem;
		logic [63:0] s_q;
		logic [2:0][63:0] sq;
		logic [63:0] rt_v;
		logic [63:0] rt_r;
		logic [2:0][31:0] um;
		logic [2:0] neg;
	} fst_t;

	fst_t pipe_s [F_LAST+1];
	logic [F_LAST:0] vld_s;
	fst_t nx0;

	always_comb begin
		nx0 = '0;
		nx0.a = in_data.porosity;
		nx0.om = 17'h10000 - {1'b0, in_data.porosity};
		nx0.d = (in_data.pore_diameter == '0) ? SMALL : in_data.pore_diameter;
		nx0.neg = {in_data.velocity_z[31], in_data.velocity_y[31], in_data.velocity_x[31]};
		nx0.um[0] = in_data.velocity_x[31] ? 32'd0 - $unsigned(in_data.velocity_x)
			: $unsigned(in_data.velocity_x);
		nx0.um[1] = in_data.velocity_y[31] ? 32'd0 - $unsigned(in_data.velocity_y)
			: $unsigned(in_data.velocity_y);
		nx0.um[2] = in_data.velocity_z[31] ? 32'd0 - $unsigned(in_data.velocity_z)
			: $unsigned(in_data.velocity_z);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pipe_s[0] <= nx0;
		end
	end

	for (genvar g = 1; g <= F_LAST; g++) begin : g_stage
		localparam bit IS_RT = (g >= F_RT0) && (g < F_RT0 + RT_STEPS);
		localparam bit IS_R = (g >= F_R0) && (g < F_R0 + R_BITS);
		localparam bit IS_S = (g >= F_S0);
		localparam int RB = IS_RT ? (62 - 2 * (g - F_RT0)) : 0;
		localparam int RI = IS_R ? (R_BITS - 1 - (g - F_R0)) : 0;
		localparam int SI = IS_S ? (S_BITS - 1 - (g - F_S0)) : 0;

		fst_t nx;
		logic [63:0] rt_bit;
		logic [47:0] r_num;
		logic [63:0] s_num;
		logic [17:0] r_try;
		logic [32:0] s_try;

		always_comb begin
			nx = pipe_s[g-1];
			rt_bit = 64'd1 << RB;
			r_num = {pipe_s[g-1].a, 32'd0};
			s_num = {pipe_s[g-1].r_q[31:0], 32'd0};
			r_try = {pipe_s[g-1].r_rem, r_num[RI]};
			s_try = {pipe_s[g-1].s_rem, s_num[SI]};
			if (g == F_SQ) begin
				for (int i = 0; i < 3; i++) begin
					nx.sq[i] = 64'(pipe_s[g-1].um[i]) * 64'(pipe_s[g-1].um[i]);
				end
			end
			if (g == F_SUM) begin
				nx.rt_v = pipe_s[g-1].sq[0] + pipe_s[g-1].sq[1] + pipe_s[g-1].sq[2];
				nx.rt_r = '0;
			end
			if (IS_RT) begin
				if (pipe_s[g-1].rt_v >= pipe_s[g-1].rt_r + rt_bit) begin
					nx.rt_v = pipe_s[g-1].rt_v - (pipe_s[g-1].rt_r + rt_bit);
					nx.rt_r = (pipe_s[g-1].rt_r >> 1) + rt_bit;
				end else begin
					nx.rt_r = pipe_s[g-1].rt_r >> 1;
				end
			end
			if (IS_R) begin
				if (r_try >= {1'b0, pipe_s[g-1].om}) begin
					nx.r_rem = 17'(r_try - {1'b0, pipe_s[g-1].om});
					nx.r_q = {pipe_s[g-1].r_q[46:0], 1'b1};
				end else begin
					nx.r_rem = r_try[16:0];
					nx.r_q = {pipe_s[g-1].r_q[46:0], 1'b0};
				end
			end
			if (g == F_SCHK) begin
				// quotient would not fit 64 bits
				nx.s_inf = {16'd0, pipe_s[g-1].r_q[47:32]} >= pipe_s[g-1].d;
				nx.s_rem = {16'd0, pipe_s[g-1].r_q[47:32]};
				nx.s_q = '0;
			end
			if (IS_S) begin
				if (s_try >= {1'b0, pipe_s[g-1].d}) begin
					nx.s_rem = 32'(s_try - {1'b0, pipe_s[g-1].d});
					nx.s_q = {pipe_s[g-1].s_q[62:0], 1'b1};
				end else begin
					nx.s_rem = s_try[31:0];
					nx.s_q = {pipe_s[g-1].s_q[62:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				pipe_s[g] <= nx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[F_LAST-1:0], in_vld};
		end
	end

	assign out_vld = vld_s[F_LAST];
	assign out_data.s = pipe_s[F_LAST].s_inf ? 64'd0 : pipe_s[F_LAST].s_q;
	assign out_data.s_inf = pipe_s[F_LAST].s_inf;
	assign out_data.mag = pipe_s[F_LAST].rt_r[31:0];
	assign out_data.um = pipe_s[F_LAST].um;
	assign out_data.neg = pipe_s[F_LAST].neg;
endmodule

[hdl/pmdf_back.sv]
// back pipeline: drag coefficient k and the three saturated force components
module pmdf_back (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_vld,
	input pmdf_pkg::pmdf_ratio_t ratio,
	input pmdf_pkg::pmdf_coef_t coef,
	output logic out_vld,
	output pmdf_pkg::pmdf_out_t out_data
);
	import pmdf_pkg::*;

	typedef struct packed {
		logic s_inf;
		logic kinf;
		logic [63:0] s2;
		logic [63:0] t;
		logic [63:0] t1;
		logic [63:0] t2;
		logic [63:0] k;
		logic [31:0] mag;
		logic [2:0][31:0] um;
		logic [2:0] neg;
		logic [2:0] zero;
		logic [2:0][63:0] pc;
		logic [2:0] povf;
	} bst_t;

	bst_t st_s1, st_s2, st_s3, st_s4, st_s5, st_s6, st_s7, st_s8;
	bst_t nx1, nx2, nx4, nx5, nx7;
	pmdf_out_t out_s9, nx9;
	logic [9:1] vld_s;

	logic [127:0] prod_ss, prod_sc, prod_cn, prod_tm;
	logic [2:0][127:0] prod_kc, prod_pu;

	pmdf_mul64 u_mul_ss (.clk, .en, .a(ratio.s), .b(ratio.s), .p(prod_ss));
	pmdf_mul64 u_mul_sc (.clk, .en, .a(ratio.s), .b({33'd0, coef.c2}), .p(prod_sc));
	pmdf_mul64 u_mul_cn (.clk, .en, .a(st_s2.s2), .b({1'b0, coef.cn}), .p(prod_cn));
	pmdf_mul64 u_mul_tm (.clk, .en, .a(st_s2.t), .b({32'd0, st_s2.mag}), .p(prod_tm));

	for (genvar i = 0; i < 3; i++) begin : g_comp
		pmdf_mul64 u_mul_kc (.clk, .en, .a(st_s5.k), .b({33'd0, coef.scale[i]}),
			.p(prod_kc[i]));
		pmdf_mul64 u_mul_pu (.clk, .en, .a(st_s7.pc[i]), .b({32'd0, st_s7.um[i]}),
			.p(prod_pu[i]));
	end

	always_comb begin
		nx1 = '0;
		nx1.s_inf = ratio.s_inf;
		nx1.mag = ratio.mag;
		nx1.um = ratio.um;
		nx1.neg = ratio.neg;
	end

	// a term counts as infinite only when its coefficients are live
	always_comb begin
		nx2 = st_s1;
		nx2.s2 = prod_ss[95:32];
		nx2.t = prod_sc[79:16];
		nx2.kinf = (st_s1.s_inf && (coef.cn != '0 || (coef.c2 != '0 && st_s1.mag != '0)))
			|| ((|prod_ss[127:96]) && coef.cn != '0)
			|| ((|prod_sc[127:80]) && st_s1.mag != '0);
	end

	always_comb begin
		nx4 = st_s3;
		nx4.t1 = prod_cn[111:48];
		nx4.t2 = prod_tm[63+VEL_FRAC_BITS:VEL_FRAC_BITS];
		nx4.kinf = st_s3.kinf || (|prod_cn[127:112])
			|| (|prod_tm[127:64+VEL_FRAC_BITS]);
	end

	always_comb begin
		logic [64:0] ksum;
		nx5 = st_s4;
		ksum = {1'b0, st_s4.t1} + {1'b0, st_s4.t2};
		nx5.k = ksum[63:0];
		nx5.kinf = st_s4.kinf || ksum[64];
		for (int i = 0; i < 3; i++) begin
			nx5.zero[i] = (coef.scale[i] == '0) || (st_s4.um[i] == '0);
		end
	end

	always_comb begin
		nx7 = st_s6;
		for (int i = 0; i < 3; i++) begin
			nx7.pc[i] = prod_kc[i][79:16];
			nx7.povf[i] = |prod_kc[i][127:80];
		end
	end

	always_comb begin
		logic [2:0][31:0] f;
		logic [2:0] flag;
		logic [63:0] q;
		logic [31:0] lim;
		logic [31:0] qc;
		logic clamp;
		nx9 = '0;
		for (int i = 0; i < 3; i++) begin
			q = prod_pu[i][95:32];
			lim = st_s8.neg[i] ? 32'h7fffffff : 32'h80000000;
			clamp = st_s8.kinf || st_s8.povf[i] || (|prod_pu[i][127:96])
				|| (q > {32'd0, lim});
			flag[i] = !st_s8.zero[i] && clamp;
			if (st_s8.zero[i]) begin
				qc = '0;
			end else if (clamp) begin
				qc = lim;
			end else begin
				qc = q[31:0];
			end
			// drag opposes the velocity
			f[i] = st_s8.neg[i] ? qc : 32'd0 - qc;
		end
		nx9.force_x = $signed(f[0]);
		nx9.force_y = $signed(f[1]);
		nx9.force_z = $signed(f[2]);
		nx9.saturated = |flag;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s1 <= nx1;
			st_s2 <= nx2;
			st_s3 <= st_s2;
			st_s4 <= nx4;
			st_s5 <= nx5;
			st_s6 <= st_s5;
			st_s7 <= nx7;
			st_s8 <= st_s7;
			out_s9 <= nx9;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[8:1], in_vld};
		end
	end

	assign out_vld = vld_s[9];
	assign out_data = out_s9;
endmodule

[hdl/porous_media_drag_force_unit.sv]
// top level: configuration registers, pipeline control and the datapath
//
// channel   direction  handshake                 payload
// in        input      in_valid / in_ready       in_data (pmdf_in_t)
// out       output     out_valid / out_ready     out_data (pmdf_out_t)
// config    input      psel, penable, pwrite     paddr, pwdata, prdata
//
// one cell per clock unless the output stalls; 114 front stages for the bit-serial
// divisions and the square root, 9 back stages for the split 64-bit multiplies
// the whole pipeline holds while out_valid is high and out_ready low
// reset clears the valid bits and loads the register defaults
module porous_media_drag_force_unit (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input pmdf_pkg::pmdf_in_t in_data,
	output logic out_valid,
	input logic out_ready,
	output pmdf_pkg::pmdf_out_t out_data,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [pmdf_pkg::ADDR_W-1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import pmdf_pkg::*;

	logic [30:0] visc_q, inert_q, scale_x_q, scale_y_q, scale_z_q;
	logic [31:0] nu_q;
	logic [62:0] cn_q;
	logic en;
	logic wr_en;
	reg_idx_t ridx;
	pmdf_coef_t coef;
	pmdf_ratio_t ratio;
	logic ratio_vld;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;
	assign ridx = reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			visc_q <= RST_VISCOUS;
			inert_q <= RST_INERTIAL;
			nu_q <= RST_NU;
			scale_x_q <= RST_SCALE;
			scale_y_q <= RST_SCALE;
			scale_z_q <= RST_SCALE;
		end else if (wr_en) begin
			unique case (ridx)
				REG_VISCOUS: visc_q <= pwdata[30:0];
				REG_INERTIAL: inert_q <= pwdata[30:0];
				REG_NU: nu_q <= pwdata;
				REG_SCALE_X: scale_x_q <= pwdata[30:0];
				REG_SCALE_Y: scale_y_q <= pwdata[30:0];
				REG_SCALE_Z: scale_z_q <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	// C1 times nu, Q15.48
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cn_q <= 63'(RST_VISCOUS) * 63'(RST_NU);
		end else begin
			cn_q <= 63'(visc_q) * 63'(nu_q);
		end
	end

	always_comb begin
		unique case (ridx)
			REG_VISCOUS: prdata = {1'b0, visc_q};
			REG_INERTIAL: prdata = {1'b0, inert_q};
			REG_NU: prdata = nu_q;
			REG_SCALE_X: prdata = {1'b0, scale_x_q};
			REG_SCALE_Y: prdata = {1'b0, scale_y_q};
			REG_SCALE_Z: prdata = {1'b0, scale_z_q};
			default: prdata = '0;
		endcase
	end

	assign coef.cn = cn_q;
	assign coef.c2 = inert_q;
	assign coef.scale = {scale_z_q, scale_y_q, scale_x_q};

	assign en = !out_valid || out_ready;
	assign in_ready = en;

	pmdf_front u_front (
		.clk,
		.arst_n,
		.en,
		.in_vld(in_valid),
		.in_data,
		.out_vld(ratio_vld),
		.out_data(ratio)
	);

	pmdf_back u_back (
		.clk,
		.arst_n,
		.en,
		.in_vld(ratio_vld),
		.ratio,
		.coef,
		.out_vld(out_valid),
		.out_data
	);

`ifndef ASSERT_OFF
	a_sat_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.saturated |->
			(out_data.force_x == 32'sh7fffffff || out_data.force_x == 32'sh80000000
			|| out_data.force_y == 32'sh7fffffff || out_data.force_y == 32'sh80000000
			|| out_data.force_z == 32'sh7fffffff || out_data.force_z == 32'sh80000000))
		else $error("saturated transaction without a clamped force");
	a_cn_track: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> cn_q == $past(63'(visc_q) * 63'(nu_q)))
		else $error("coefficient product out of step with registers");
`endif
endmodule

[test/testbench.sv]
// testbench for the porous media drag force unit: predicted drag compared per cell
`timescale 1ns / 100ps

module testbench;
	import pmdf_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	pmdf_in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	pmdf_out_t out_data;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	porous_media_drag_force_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	// register shadow
	logic [30:0] c1 = RST_VISCOUS;
	logic [30:0] c2 = RST_INERTIAL;
	logic [31:0] nu = RST_NU;
	logic [30:0] scl [3] = '{RST_SCALE, RST_SCALE, RST_SCALE};

	pmdf_out_t drag_queue [$];
	int errors = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_cycles = 0;

	function automatic logic [63:0] mul_shift(input logic [63:0] a, input logic [63:0] b,
			input int sh, output logic ovf);
		logic [127:0] p;
		p = ({64'd0, a} * {64'd0, b}) >> sh;
		ovf = (p[127:64] != 0);
		return p[63:0];
	endfunction

	function automatic logic [31:0] isqrt(input logic [63:0] v);
		logic [31:0] r;
		logic [31:0] t;
		r = 0;
		for (int b = 31; b >= 0; b--) begin
			t = r | (32'd1 << b);
			if ({32'd0, t} * {32'd0, t} <= v)
				r = t;
		end
		return r;
	endfunction

	function automatic logic [31:0] magnitude(input logic [31:0] raw);
		return raw[31] ? (~raw + 32'd1) : raw;
	endfunction

	function automatic logic [31:0] drag_component(input logic [63:0] k, input logic kinf,
			input logic [30:0] c, input logic [31:0] raw, inout logic flag);
		logic [31:0] um;
		logic [63:0] p;
		logic [63:0] q;
		logic [63:0] lim;
		logic ovf;
		um = magnitude(raw);
		lim = raw[31] ? 64'h7FFF_FFFF : 64'h8000_0000;
		q = 0;
		ovf = 0;
		if (c == 0 || um == 0)
			return 32'd0;
		if (kinf)
			ovf = 1;
		else begin
			p = mul_shift(k, {33'd0, c}, 16, ovf);
			if (!ovf)
				q = mul_shift(p, {32'd0, um}, 32, ovf);
		end
		if (ovf || q > lim) begin
			flag = 1;
			q = lim;
		end
		return raw[31] ? q[31:0] : (~q[31:0] + 32'd1);
	endfunction

	function automatic pmdf_out_t predict_drag(input pmdf_in_t c);
		pmdf_out_t r;
		logic [63:0] d;
		logic [63:0] ratio;
		logic [127:0] num;
		logic [63:0] s;
		logic [63:0] cn;
		logic [63:0] ux, uy, uz;
		logic [31:0] mag;
		logic [63:0] t1, t2, k, tmp;
		logic sinf, kinf, ovf, flag;
		s = 0; t1 = 0; t2 = 0; k = 0;
		sinf = 0; kinf = 0; flag = 0;
		d = (c.pore_diameter == 0) ? {32'd0, SMALL} : {32'd0, c.pore_diameter};
		ratio = ({16'd0, c.porosity, 32'd0}) / (64'd65536 - c.porosity);
		if ((ratio >> 32) >= d)
			sinf = 1;
		else begin
			num = {ratio, 64'd0} >> 32;
			s = 64'(num / {64'd0, d});
		end
		cn = {33'd0, c1} * {32'd0, nu};
		ux = {32'd0, magnitude(c.velocity_x)};
		uy = {32'd0, magnitude(c.velocity_y)};
		uz = {32'd0, magnitude(c.velocity_z)};
		mag = isqrt(ux * ux + uy * uy + uz * uz);
		if (!(cn == 0 || (!sinf && s == 0))) begin
			if (sinf)
				kinf = 1;
			else begin
				tmp = mul_shift(s, s, 32, ovf);
				if (!ovf)
					t1 = mul_shift(tmp, cn, 48, ovf);
				if (ovf)
					kinf = 1;
			end
		end
		if (!(c2 == 0 || mag == 0 || (!sinf && s == 0))) begin
			if (sinf)
				kinf = 1;
			else begin
				tmp = mul_shift(s, {33'd0, c2}, 16, ovf);
				if (!ovf)
					t2 = mul_shift(tmp, {32'd0, mag}, VEL_FRAC_BITS, ovf);
				if (ovf)
					kinf = 1;
			end
		end
		if (!kinf) begin
			k = t1 + t2;
			if (k < t1)
				kinf = 1;
		end
		r.force_x = drag_component(k, kinf, scl[0], c.velocity_x, flag);
		r.force_y = drag_component(k, kinf, scl[1], c.velocity_y, flag);
		r.force_z = drag_component(k, kinf, scl[2], c.velocity_z, flag);
		r.saturated = flag;
		return r;
	endfunction

	// result side: stall pattern plus a counted hold-off
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			out_ready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		pmdf_out_t exp_f;
		if (out_valid && out_ready) begin
			if (drag_queue.size() == 0) begin
				errors++;
				$display("%0t: unexpected transaction, actual %h", $time, out_data);
			end else begin
				exp_f = drag_queue.pop_front();
				if (out_data.force_x !== exp_f.force_x) begin
					errors++;
					$display("%0t: force_x expected %0d actual %0d", $time,
						exp_f.force_x, out_data.force_x);
				end
				if (out_data.force_y !== exp_f.force_y) begin
					errors++;
					$display("%0t: force_y expected %0d actual %0d", $time,
						exp_f.force_y, out_data.force_y);
				end
				if (out_data.force_z !== exp_f.force_z) begin
					errors++;
					$display("%0t: force_z expected %0d actual %0d", $time,
						exp_f.force_z, out_data.force_z);
				end
				if (out_data.saturated !== exp_f.saturated) begin
					errors++;
					$display("%0t: saturated expected %0b actual %0b", $time,
						exp_f.saturated, out_data.saturated);
				end
			end
		end
	end

	task automatic send_cell(input pmdf_in_t c);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= c;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
		drag_queue.push_back(predict_drag(c));
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (drag_queue.size() != 0)
			@(posedge clk);
		repeat (130) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'({idx, 2'b00});
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(negedge clk); while (!pready);
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_VISCOUS: c1 = v[30:0];
			REG_INERTIAL: c2 = v[30:0];
			REG_NU: nu = v;
			REG_SCALE_X: scl[0] = v[30:0];
			REG_SCALE_Y: scl[1] = v[30:0];
			REG_SCALE_Z: scl[2] = v[30:0];
			default: ;
		endcase
	endtask

	task automatic write_all(input logic [31:0] v1, input logic [31:0] v2,
			input logic [31:0] vn, input logic [31:0] sx, input logic [31:0] sy,
			input logic [31:0] sz);
		write_reg(REG_VISCOUS, v1);
		write_reg(REG_INERTIAL, v2);
		write_reg(REG_NU, vn);
		write_reg(REG_SCALE_X, sx);
		write_reg(REG_SCALE_Y, sy);
		write_reg(REG_SCALE_Z, sz);
	endtask

	function automatic logic [31:0] rand_velocity();
		logic [31:0] v;
		if ($urandom_range(9) == 0)
			return $urandom();
		v = $urandom() >> $urandom_range(31, 8);
		return $urandom_range(1) ? (~v + 32'd1) : v;
	endfunction

	function automatic pmdf_in_t rand_cell();
		pmdf_in_t c;
		case ($urandom_range(3))
			0: c.porosity = 16'($urandom());
			1: c.porosity = 16'($urandom_range(65535, 60000));
			default: c.porosity = 16'($urandom() >> $urandom_range(15));
		endcase
		c.pore_diameter = ($urandom_range(19) == 0) ? 32'd0 : $urandom() >> $urandom_range(31);
		c.velocity_x = rand_velocity();
		c.velocity_y = rand_velocity();
		c.velocity_z = rand_velocity();
		return c;
	endfunction

	task automatic test_directed();
		pmdf_in_t c;
		logic [31:0] vel [6] = '{32'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
			32'd65536, 32'hFFFF_0000};
		logic [15:0] por [4] = '{16'd0, 16'd1, 16'd32768, 16'hFFFF};
		logic [31:0] dia [4] = '{32'd0, 32'd1, 32'h0010_0000, 32'hFFFF_FFFF};
		for (int i = 0; i < 4; i++)
			for (int j = 0; j < 4; j++) begin
				c.porosity = por[i];
				c.pore_diameter = dia[j];
				c.velocity_x = vel[(i + j) % 6];
				c.velocity_y = vel[(i + 2 * j + 1) % 6];
				c.velocity_z = vel[(2 * i + j + 2) % 6];
				send_cell(c);
			end
		wait_drained();
	endtask

	task automatic test_random(input int n, input int idle, input int stall);
		send_idle_pct = idle;
		recv_stall_pct = stall;
		for (int i = 0; i < n; i++)
			send_cell(rand_cell());
		wait_drained();
		send_idle_pct = 0;
		recv_stall_pct = 0;
	endtask

	task automatic test_backpressure();
		hold_cycles = 500;
		for (int i = 0; i < 300; i++)
			send_cell(rand_cell());
		wait_drained();
	endtask

	task automatic test_register_settings();
		write_all(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
		test_random(60, 0, 0);
		write_all(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF);
		test_random(60, 0, 0);
		write_all(32'd655360, 32'd0, 32'h0001_0000, 32'd32768, 32'd0, 32'd131072);
		test_random(60, 6, 6);
		for (int i = 0; i < 3; i++) begin
			write_all($urandom() >> $urandom_range(31), $urandom() >> $urandom_range(31),
				$urandom() >> $urandom_range(31), $urandom() >> $urandom_range(31),
				$urandom() >> $urandom_range(31), $urandom() >> $urandom_range(31));
			test_random(60, 0, 56);
		end
		write_all(32'(RST_VISCOUS), 32'(RST_INERTIAL), RST_NU, 32'(RST_SCALE),
			32'(RST_SCALE), 32'(RST_SCALE));
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(300, 0, 0);
		test_random(300, 56, 0);
		test_random(300, 0, 56);
		test_random(300, 6, 6);
		test_backpressure();
		test_register_settings();
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#20ms;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

[porous_media_drag_force_unit.f]
hdl/pmdf_pkg.sv
hdl/pmdf_mul64.sv
hdl/pmdf_front.sv
hdl/pmdf_back.sv
hdl/porous_media_drag_force_unit.sv
test/testbench.sv
